// ===== hdl/eulerian_circuit_finder_defines.svh =====
// Assertion helpers shared by the block's checks.
`ifndef EULERIAN_CIRCUIT_FINDER_DEFINES_SVH
`define EULERIAN_CIRCUIT_FINDER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define ECF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ecf same-cycle check failed");

// Next-cycle implication, sampled on clk and held off during rst.
`define ECF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ecf next-cycle check failed");

`endif

// ===== hdl/ecf_pkg.sv =====
package ecf_pkg;

  localparam int COLOR_W = 6;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_WA,
    S_INS_WB,
    S_FAIL_SET,
    S_WALK_INIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_STEP_B,
    S_POP_WAIT,
    S_CHECK,
    S_LOAD_PREV,
    S_EMIT_RD,
    S_LOAD_OUT,
    S_RESULT
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_INS_WA,
    OP_INS_WB,
    OP_FAIL,
    OP_WALK_INIT,
    OP_SCAN_RD,
    OP_SCAN_NEXT,
    OP_FOUND,
    OP_STEP_B,
    OP_POP,
    OP_POP_LOAD,
    OP_EMIT_INIT,
    OP_LOAD_PREV,
    OP_EMIT_RD,
    OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    logic sweep_last;
    logic edge_ok;
    logic last;
    logic parity_odd;
    logic cnt_nz;
    logic col_last;
    logic depth_one;
    logic len_ok;
    logic len_short;
    logic out_last;
  } dp_status_t;

endpackage

// ===== hdl/ecf_if.sv =====
interface ecf_in_if;
  import ecf_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] color_a;
  logic [COLOR_W-1:0] color_b;
  logic               last_bead;
  modport source (output valid, color_a, color_b, last_bead, input ready);
  modport sink (input valid, color_a, color_b, last_bead, output ready);
endinterface

interface ecf_out_if;
  import ecf_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] from_color;
  logic [COLOR_W-1:0] to_color;
  logic               lost;
  logic               last_result;
  modport source (output valid, from_color, to_color, lost, last_result, input ready);
  modport sink (input valid, from_color, to_color, lost, last_result, output ready);
endinterface

// ===== hdl/ecf_ctrl.sv =====
module ecf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               out_ready,
  input  ecf_pkg::dp_status_t st,
  output ecf_pkg::dp_op_t    op,
  output logic               in_ready,
  output logic               out_valid
);
  import ecf_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    ctrl_state_t after_ins;
    if (!st.last)          after_ins = S_IDLE;
    else if (st.parity_odd) after_ins = S_FAIL_SET;
    else                   after_ins = S_WALK_INIT;
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (st.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_ACCEPT;
          state_next = S_INS_WA;
        end
      end
      S_INS_WA: begin
        if (st.edge_ok) begin
          op         = OP_INS_WA;
          state_next = S_INS_WB;
        end else begin
          state_next = after_ins;
        end
      end
      S_INS_WB: begin
        op         = OP_INS_WB;
        state_next = after_ins;
      end
      S_FAIL_SET: begin
        op         = OP_FAIL;
        state_next = S_RESULT;
      end
      S_WALK_INIT: begin
        op         = OP_WALK_INIT;
        state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        op         = OP_SCAN_RD;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        priority if (st.cnt_nz) begin
          op         = OP_FOUND;
          state_next = S_STEP_B;
        end else if (!st.col_last) begin
          op         = OP_SCAN_NEXT;
          state_next = S_SCAN_RD;
        end else begin
          // Dead end: the node joins the circuit and the walk backs up.
          op         = OP_POP;
          state_next = st.depth_one ? S_CHECK : S_POP_WAIT;
        end
      end
      S_STEP_B: begin
        op         = OP_STEP_B;
        state_next = S_SCAN_RD;
      end
      S_POP_WAIT: begin
        op         = OP_POP_LOAD;
        state_next = S_SCAN_RD;
      end
      S_CHECK: begin
        priority if (!st.len_ok) begin
          state_next = S_FAIL_SET;
        end else if (st.len_short) begin
          state_next = S_CLEAR;
        end else begin
          op         = OP_EMIT_INIT;
          state_next = S_LOAD_PREV;
        end
      end
      S_LOAD_PREV: begin
        op         = OP_LOAD_PREV;
        state_next = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        op         = OP_EMIT_RD;
        state_next = S_LOAD_OUT;
      end
      S_LOAD_OUT: begin
        op         = OP_LOAD_OUT;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = st.out_last ? S_CLEAR : S_EMIT_RD;
      end
      default: state_next = S_CLEAR;
    endcase
  end
endmodule

// ===== hdl/ecf_datapath.sv =====
module ecf_datapath #(
  parameter int NUM_COLORS = 50,
  parameter int MAX_BEADS  = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ecf_pkg::dp_op_t             op,
  input  logic [ecf_pkg::COLOR_W-1:0] color_a,
  input  logic [ecf_pkg::COLOR_W-1:0] color_b,
  input  logic                        last_bead,
  output ecf_pkg::dp_status_t         st,
  output logic [ecf_pkg::COLOR_W-1:0] from_color,
  output logic [ecf_pkg::COLOR_W-1:0] to_color,
  output logic                        lost,
  output logic                        last_result
);
  import ecf_pkg::*;

  localparam int CW    = $clog2(NUM_COLORS);
  localparam int AW    = 2 * CW;
  localparam int CNT_W = $clog2(MAX_BEADS + 1);
  localparam int STK   = MAX_BEADS + 2;
  localparam int SW    = $clog2(STK);
  localparam int DW    = $clog2(STK + 1);

  logic [CNT_W-1:0] cnt_mem [2**AW];
  logic [CW-1:0]    stk_mem [STK];
  logic [CW-1:0]    circ_mem [STK];

  logic [AW-1:0]         sweep;
  logic [CNT_W-1:0]      bead_count;
  logic [NUM_COLORS-1:0] parity;
  logic [CW-1:0]         start_node;
  logic [CW-1:0]         a0, b0;
  logic                  edge_ok, last;
  logic [CNT_W-1:0]      rdata, cnt;
  logic [CW-1:0]         v, col;
  logic [DW-1:0]         depth, length, k;
  logic [CW-1:0]         stk_rdata, circ_rdata, prev;

  logic [COLOR_W-1:0] a_m1, b_m1;
  logic [CW-1:0]      a_in, b_in;
  logic               in_ok;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en;
  logic [CNT_W-1:0]   wr_data;
  logic [SW-1:0]      circ_raddr;
  logic [DW-1:0]      depth_m1;

  assign a_m1     = color_a - COLOR_W'(1);
  assign b_m1     = color_b - COLOR_W'(1);
  assign a_in     = a_m1[CW-1:0];
  assign b_in     = b_m1[CW-1:0];
  assign in_ok    = (color_a != '0) && (color_b != '0)
                 && ({1'b0, color_a} <= (COLOR_W + 1)'(NUM_COLORS))
                 && ({1'b0, color_b} <= (COLOR_W + 1)'(NUM_COLORS))
                 && (bead_count != CNT_W'(MAX_BEADS));
  assign depth_m1 = depth - DW'(1);

  always_comb begin
    rd_addr    = {v, col};
    wr_en      = 1'b0;
    wr_addr    = {a0, b0};
    wr_data    = cnt;
    circ_raddr = k[SW-1:0];
    unique case (op)
      OP_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = sweep;
        wr_data = '0;
      end
      OP_ACCEPT: rd_addr = {a_in, b_in};
      OP_INS_WA: begin
        wr_en   = 1'b1;
        wr_data = rdata + CNT_W'(1);
      end
      OP_INS_WB: begin
        wr_en   = 1'b1;
        wr_addr = {b0, a0};
      end
      OP_FOUND: begin
        wr_en   = 1'b1;
        wr_addr = {v, col};
        wr_data = rdata - CNT_W'(1);
      end
      OP_STEP_B: begin
        wr_en   = 1'b1;
        wr_addr = {col, v};
      end
      OP_EMIT_INIT: circ_raddr = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata      <= cnt_mem[rd_addr];
    circ_rdata <= circ_mem[circ_raddr];
    stk_rdata  <= stk_mem[depth_m1[SW-1:0]];
    if (wr_en) cnt_mem[wr_addr] <= wr_data;
    if (op == OP_WALK_INIT) stk_mem[0] <= start_node;
    if (op == OP_FOUND && depth < DW'(STK)) stk_mem[depth[SW-1:0]] <= v;
    if (op == OP_POP && length < DW'(STK)) circ_mem[length[SW-1:0]] <= v;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep      <= '0;
      bead_count <= '0;
      parity     <= '0;
      start_node <= '0;
    end else begin
      unique case (op)
        OP_CLEAR: begin
          sweep      <= sweep + AW'(1);
          bead_count <= '0;
          parity     <= '0;
          start_node <= '0;
        end
        OP_ACCEPT: begin
          if (in_ok) begin
            bead_count <= bead_count + CNT_W'(1);
            start_node <= a_in;
            // Self-loops add nothing to the degree parity.
            if (a_in != b_in) begin
              parity[a_in] <= ~parity[a_in];
              parity[b_in] <= ~parity[b_in];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Walk and emission registers.
  always_ff @(posedge clk) begin
    unique case (op)
      OP_ACCEPT: begin
        a0      <= a_in;
        b0      <= b_in;
        edge_ok <= in_ok;
        last    <= last_bead;
      end
      OP_INS_WA: cnt <= rdata + CNT_W'(1);
      OP_FAIL: begin
        from_color  <= '0;
        to_color    <= '0;
        lost        <= 1'b1;
        last_result <= 1'b1;
      end
      OP_WALK_INIT: begin
        v      <= start_node;
        col    <= '0;
        depth  <= DW'(1);
        length <= '0;
      end
      OP_SCAN_NEXT: col <= col + CW'(1);
      OP_FOUND: begin
        cnt <= rdata - CNT_W'(1);
        if (depth < DW'(STK)) depth <= depth + DW'(1);
      end
      OP_STEP_B: begin
        v   <= col;
        col <= '0;
      end
      OP_POP: begin
        if (length < DW'(STK)) length <= length + DW'(1);
        depth <= depth_m1;
      end
      OP_POP_LOAD: begin
        v   <= stk_rdata;
        col <= '0;
      end
      OP_EMIT_INIT: k <= DW'(1);
      OP_LOAD_PREV: prev <= circ_rdata;
      OP_LOAD_OUT: begin
        from_color  <= COLOR_W'(prev) + COLOR_W'(1);
        to_color    <= COLOR_W'(circ_rdata) + COLOR_W'(1);
        lost        <= 1'b0;
        last_result <= (k + DW'(1) == length);
        prev        <= circ_rdata;
        k           <= k + DW'(1);
      end
      default: ;
    endcase
  end

  assign st.sweep_last = &sweep;
  assign st.edge_ok    = edge_ok;
  assign st.last       = last;
  assign st.parity_odd = |parity;
  assign st.cnt_nz     = rdata != '0;
  assign st.col_last   = col == CW'(NUM_COLORS - 1);
  assign st.depth_one  = depth == DW'(1);
  assign st.len_ok     = length == DW'(bead_count) + DW'(1);
  assign st.len_short  = length < DW'(2);
  assign st.out_last   = last_result;
endmodule

// ===== hdl/eulerian_circuit_finder.sv =====
// Channel  | Dir | Payload                                     | Item
// beads    | in  | color_a, color_b, last_bead                 | one edge
// results  | out | from_color, to_color, lost, last_result     | one circuit pair
//
// An edge is a read-modify-write of the count memory, one write for each
// direction; an edge that is out of range or over the bead limit writes nothing.
// After the final edge the walk scans a matrix row one column at a time, in a
// read state then a check state, once to step along an edge and once in full
// when it backs up; each result takes a read, a load and a result state.
// After reset and after every case a clearing pass writes all the count memory's
// 2**(2*clog2(NUM_COLORS)) entries (4096 at the default); beads is not ready then.
// A stalled result holds its register and the block waits for it.
`include "eulerian_circuit_finder_defines.svh"

module eulerian_circuit_finder #(
  parameter int NUM_COLORS = 50,
  parameter int MAX_BEADS  = 64
) (
  input logic        clk,
  input logic        rst,
  ecf_in_if.sink     beads,
  ecf_out_if.source  results
);
  import ecf_pkg::*;

  dp_op_t     op;
  dp_status_t st;

  ecf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (beads.valid),
    .out_ready (results.ready),
    .st        (st),
    .op        (op),
    .in_ready  (beads.ready),
    .out_valid (results.valid)
  );

  ecf_datapath #(
    .NUM_COLORS (NUM_COLORS),
    .MAX_BEADS  (MAX_BEADS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .color_a     (beads.color_a),
    .color_b     (beads.color_b),
    .last_bead   (beads.last_bead),
    .st          (st),
    .from_color  (results.from_color),
    .to_color    (results.to_color),
    .lost        (results.lost),
    .last_result (results.last_result)
  );

  `ECF_ASSERT_IMP(a_no_overlap, results.valid, !beads.ready)
  `ECF_ASSERT_IMP(a_fail_single, results.valid && results.lost,
                  results.last_result && results.from_color == '0)
  `ECF_ASSERT_NEXT(a_clear_after_case,
                   results.valid && results.ready && results.last_result, !beads.ready)
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import ecf_pkg::*;

  localparam int COLORS = 50;
  localparam int BEAD_LIMIT = 64;
  localparam int IDLE_LIMIT = 60000;

  typedef struct {
    logic [COLOR_W-1:0] from_color;
    logic [COLOR_W-1:0] to_color;
    logic               lost;
    logic               last_result;
  } pair_t;

  logic clk;
  logic rst;

  ecf_in_if  bead_if ();
  ecf_out_if res_if ();

  eulerian_circuit_finder u_top (
    .clk     (clk),
    .rst     (rst),
    .beads   (bead_if),
    .results (res_if)
  );

  // Shadow copy of the block's case state.
  int unsigned edge_cnt [COLORS][COLORS];
  int unsigned beads_held;
  int unsigned walk_origin;

  pair_t circuit_pairs [$];
  logic [COLOR_W-1:0] case_a [$];
  logic [COLOR_W-1:0] case_b [$];

  int errors = 0;
  int beads_sent = 0;
  int cases_run = 0;
  int pairs_seen = 0;
  int lost_seen = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int unsigned cyc = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_case_state();
    foreach (edge_cnt[r, c]) edge_cnt[r][c] = 0;
    beads_held = 0;
    walk_origin = 0;
  endfunction

  // Counts one edge and, on the final edge, predicts the circuit pairs.
  function automatic void predict_circuit(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b,
                                          logic last);
    int stk [BEAD_LIMIT+2];
    int circ [BEAD_LIMIT+2];
    int depth;
    int len;
    int v;
    int nxt;
    int sum;
    bit ok;
    pair_t p;
    if (a >= 1 && a <= COLORS && b >= 1 && b <= COLORS && beads_held < BEAD_LIMIT) begin
      walk_origin = a - 1;
      edge_cnt[a-1][b-1]++;
      if (a != b) edge_cnt[b-1][a-1]++;
      beads_held++;
    end
    if (!last) return;
    ok = 1'b1;
    for (int r = 0; r < COLORS; r++) begin
      sum = 0;
      for (int c = 0; c < COLORS; c++) if (c != r) sum += edge_cnt[r][c];
      if (sum % 2) ok = 1'b0;
    end
    len = 0;
    if (ok) begin
      depth = 0;
      v = walk_origin;
      stk[depth++] = v;
      while (depth > 0) begin
        nxt = COLORS;
        for (int i = 0; i < COLORS; i++) begin
          if (edge_cnt[v][i] != 0) begin
            nxt = i;
            break;
          end
        end
        if (nxt < COLORS) begin
          if (depth < BEAD_LIMIT + 2) stk[depth++] = v;
          edge_cnt[v][nxt]--;
          if (nxt != v) edge_cnt[nxt][v]--;
          v = nxt;
        end else begin
          if (len < BEAD_LIMIT + 2) circ[len++] = v;
          depth--;
          v = stk[depth];
        end
      end
      ok = (len == beads_held + 1);
    end
    if (!ok) begin
      p.from_color = '0;
      p.to_color = '0;
      p.lost = 1'b1;
      p.last_result = 1'b1;
      circuit_pairs = {circuit_pairs, p};
    end else begin
      for (int k = 0; k + 1 < len; k++) begin
        p.from_color = COLOR_W'(circ[k] + 1);
        p.to_color = COLOR_W'(circ[k+1] + 1);
        p.lost = 1'b0;
        p.last_result = (k + 2 == len);
        circuit_pairs = {circuit_pairs, p};
      end
    end
    clear_case_state();
  endfunction

  // Sends one bead in bursts with random gaps between them.
  task automatic send_bead(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b, logic last);
    if (burst_left == 0) begin
      bead_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    bead_if.valid <= 1'b1;
    bead_if.color_a <= a;
    bead_if.color_b <= b;
    bead_if.last_bead <= last;
    do @(posedge clk); while (!bead_if.ready);
    predict_circuit(a, b, last);
    beads_sent++;
    if (last) cases_run++;
  endtask

  function automatic void add_edge(int a, int b);
    case_a = {case_a, COLOR_W'(a)};
    case_b = {case_b, COLOR_W'(b)};
  endfunction

  task automatic send_case();
    for (int i = 0; i < case_a.size(); i++) begin
      send_bead(case_a[i], case_b[i], i == case_a.size() - 1);
    end
    case_a.delete();
    case_b.delete();
  endtask

  // A closed walk over colors lo..hi that ends at its start color; every degree ends up even.
  function automatic void add_closed_walk(int n, int lo, int hi);
    int s;
    int cur;
    int nxt;
    s = $urandom_range(lo, hi);
    cur = s;
    for (int i = 0; i < n - 1; i++) begin
      nxt = $urandom_range(lo, hi);
      add_edge(cur, nxt);
      cur = nxt;
    end
    add_edge(cur, s);
  endfunction

  task automatic wait_drained();
    bead_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (circuit_pairs.size() != 0);
  endtask

  task automatic test_extremes();
    add_edge(1, 50);
    add_edge(50, 1);
    send_case();
    add_edge(50, 50);
    send_case();
    add_edge(63, 5);
    add_edge(1, 1);
    add_edge(0, 7);
    send_case();
  endtask

  task automatic test_failures();
    add_edge(1, 2);
    send_case();
    add_edge(1, 2);
    add_edge(2, 1);
    add_edge(3, 4);
    add_edge(4, 3);
    send_case();
    // A case whose only bead is out of range gives no result at all.
    add_edge(0, 0);
    send_case();
    add_edge(3, 51);
    add_edge(42, 21);
    add_edge(21, 42);
    add_edge(21, 0);
    send_case();
  endtask

  task automatic test_bead_limit();
    for (int i = 0; i < BEAD_LIMIT + 2; i++) begin
      if (i % 2) add_edge(2, 1);
      else add_edge(1, 2);
    end
    send_case();
    wait_drained();
  endtask

  task automatic test_random_cases(int target);
    int kind;
    int lo;
    while (beads_sent < target) begin
      kind = $urandom_range(0, 9);
      lo = $urandom_range(1, 44);
      if (kind < 6) begin
        if ($urandom_range(0, 1)) add_closed_walk($urandom_range(1, 10), lo, lo + 5);
        else add_closed_walk($urandom_range(1, 8), 1, COLORS);
      end else if (kind == 6) begin
        add_closed_walk($urandom_range(1, 4), 1, 20);
        add_closed_walk($urandom_range(1, 4), 30, 50);
      end else if (kind == 7) begin
        add_closed_walk($urandom_range(2, 6), lo, lo + 6);
        add_edge($urandom_range(0, 63), $urandom_range(0, 63));
        add_closed_walk(1, lo, lo + 6);
      end else begin
        repeat ($urandom_range(1, 5)) add_edge($urandom_range(0, 63), $urandom_range(0, 63));
      end
      send_case();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  // Receiver: alternates between a stall-free stretch and random stalls.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= cyc[8] ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (circuit_pairs.size() == 0) begin
        $display("%0t: result with nothing expected: from %0d to %0d lost %0b last %0b",
                 $time, res_if.from_color, res_if.to_color, res_if.lost, res_if.last_result);
        errors++;
      end else begin
        pair_t p;
        p = circuit_pairs.pop_front();
        if (res_if.from_color !== p.from_color) begin
          $display("%0t: from_color expected %0d actual %0d", $time, p.from_color,
                   res_if.from_color);
          errors++;
        end
        if (res_if.to_color !== p.to_color) begin
          $display("%0t: to_color expected %0d actual %0d", $time, p.to_color, res_if.to_color);
          errors++;
        end
        if (res_if.lost !== p.lost) begin
          $display("%0t: lost expected %0b actual %0b", $time, p.lost, res_if.lost);
          errors++;
        end
        if (res_if.last_result !== p.last_result) begin
          $display("%0t: last_result expected %0b actual %0b", $time, p.last_result,
                   res_if.last_result);
          errors++;
        end
      end
      pairs_seen++;
      if (res_if.lost === 1'b1) lost_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (bead_if.valid && bead_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    bead_if.valid = 1'b0;
    bead_if.color_a = '0;
    bead_if.color_b = '0;
    bead_if.last_bead = 1'b0;
    clear_case_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_failures();
    test_random_cases(40);
    test_bead_limit();
    test_random_cases(130);
    wait_drained();
    repeat (300) @(posedge clk);
    $display("Ran %0d beads in %0d cases: %0d circuit pairs checked, %0d lost-bead results.",
             beads_sent, cases_run, pairs_seen, lost_seen);
    $display("Covered closed walks, self-loops, odd degrees, split graphs and the bead limit.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ecf_pkg.sv
hdl/ecf_if.sv
hdl/ecf_ctrl.sv
hdl/ecf_datapath.sv
hdl/eulerian_circuit_finder.sv
dv/tb.sv
